// File: rtl/swa_pkg.sv
// Shared constants and command/status types for the sliding window average block.
package swa_pkg;

    localparam int MAX_WINDOW    = 1024;
    localparam int PTR_BITS      = $clog2(MAX_WINDOW);
    localparam int SAMPLE_BITS   = 18;
    localparam int FRACTION_BITS = 16;
    localparam int SUM_BITS      = 28;
    localparam int AVG_BITS      = 34;
    localparam int HELD_BITS     = 11;
    localparam int WSIZE_BITS    = 11;

    // Magnitude of the scaled sum and the divider geometry
    localparam int MAG_BITS      = SUM_BITS + FRACTION_BITS;
    localparam int DIV_STEPS     = AVG_BITS;
    localparam int CNT_BITS      = $clog2(DIV_STEPS);
    localparam int REM_BITS      = HELD_BITS;

    // Configuration port
    localparam int PADDR_BITS    = 3;
    localparam int PDATA_BITS    = 32;
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic [WSIZE_BITS-1:0] WINDOW_RESET = WSIZE_BITS'(1);

    typedef struct packed {
        logic capture;  // latch the accepted item
        logic update;   // update ring, sum and fill count
        logic load;     // load the divider
        logic step;     // one quotient bit
        logic emit;     // move the quotient into the output register
    } t_swa_cmd;

    typedef struct packed {
        logic out_free; // output register can take a result
    } t_swa_sts;

endpackage

// File: rtl/swa_in_if.sv
// Input channel carrying one sample per item.
interface swa_in_if import swa_pkg::*; ;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/swa_out_if.sv
// Output channel carrying the average and the count of held samples.
interface swa_out_if import swa_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic signed [AVG_BITS-1:0] average;
    logic [HELD_BITS-1:0]       samples_held;

    modport source (output valid, output average, output samples_held, input ready);
    modport sink   (input valid, input average, input samples_held, output ready);
endinterface

// File: rtl/swa_ctrl.sv
// Sequencer for the sliding window average: update, divider load, division, hand-off.
module swa_ctrl import swa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_swa_sts i_sts,
    output t_swa_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_cmd.capture = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the quotient until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTH
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_state == ST_DIVIDE) && (r_cnt == '0))
        else $error("divider did not start at step zero");

    a_finish_after_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_FINISH) |-> $past(r_cnt) == CNT_BITS'(DIV_STEPS - 1))
        else $error("division ended after the wrong number of steps");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

// File: rtl/swa_dp.sv
// Datapath: sample ring, running sum, fill count, serial divider and output register.
module swa_dp import swa_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_swa_cmd                      i_cmd,
    output t_swa_sts                      o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_wr,
    input  logic [WSIZE_BITS-1:0]         i_cfg_data,
    output logic [WSIZE_BITS-1:0]         o_window_size,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [AVG_BITS-1:0]    o_average,
    output logic [HELD_BITS-1:0]          o_samples_held
);

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [WSIZE_BITS-1:0]         r_wsize;
    logic [PTR_BITS-1:0]           r_ptr;
    logic [HELD_BITS-1:0]          r_fill;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic [REM_BITS-1:0]           r_rem;
    logic [AVG_BITS-1:0]           r_quo;
    logic                          r_out_valid;
    logic signed [AVG_BITS-1:0]    r_average;
    logic [HELD_BITS-1:0]          r_held;

    logic [WSIZE_BITS-1:0]         w_eff;
    logic                          w_full;
    logic [PTR_BITS-1:0]           w_waddr;
    logic [PTR_BITS-1:0]           w_ptr_inc;
    logic signed [SUM_BITS-1:0]    w_drop;
    logic signed [SUM_BITS-1:0]    w_sum_next;
    logic [SUM_BITS-1:0]           w_abs;
    logic [MAG_BITS-1:0]           w_mag;
    logic [REM_BITS:0]             w_rem_sh;
    logic [REM_BITS:0]             w_rem_sub;
    logic                          w_qbit;

    // Effective window: zero means one, anything past the store depth saturates
    always_comb begin
        if (r_wsize == '0) begin
            w_eff = WSIZE_BITS'(1);
        end else if (r_wsize > WSIZE_BITS'(MAX_WINDOW)) begin
            w_eff = WSIZE_BITS'(MAX_WINDOW);
        end else begin
            w_eff = r_wsize;
        end
    end

    assign w_full     = (r_fill >= w_eff);
    assign w_waddr    = w_full ? r_ptr : r_fill[PTR_BITS-1:0];
    assign w_ptr_inc  = r_ptr + PTR_BITS'(1);
    assign w_drop     = w_full ? SUM_BITS'(r_rd) : '0;
    assign w_sum_next = r_sum - w_drop + SUM_BITS'(r_sample);

    assign w_abs      = r_sum[SUM_BITS-1] ? SUM_BITS'(-r_sum) : r_sum;
    assign w_mag      = {w_abs, {FRACTION_BITS{1'b0}}};

    assign w_rem_sh   = {r_rem, r_quo[AVG_BITS-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, r_fill};
    assign w_qbit     = (w_rem_sh >= {1'b0, r_fill});

    // Ring store: one write port, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[w_waddr] <= r_sample;
        end
        r_rd <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WINDOW_RESET;
            r_ptr   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
        end else if (i_cfg_wr) begin
            r_wsize <= i_cfg_data;
            r_ptr   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
        end else if (i_cmd.update) begin
            r_sum <= w_sum_next;
            if (w_full) begin
                r_ptr <= ({1'b0, w_ptr_inc} >= w_eff) ? '0 : w_ptr_inc;
            end else begin
                r_fill <= r_fill + HELD_BITS'(1);
            end
        end
    end

    // Restoring divider on the magnitude; the quotient is known to fit AVG_BITS
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= REM_BITS'(w_mag >> AVG_BITS);
            r_quo <= w_mag[AVG_BITS-1:0];
        end else if (i_cmd.step) begin
            r_rem <= w_qbit ? w_rem_sub[REM_BITS-1:0] : w_rem_sh[REM_BITS-1:0];
            r_quo <= {r_quo[AVG_BITS-2:0], w_qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_average <= r_sum[SUM_BITS-1] ? -$signed(r_quo) : $signed(r_quo);
            r_held    <= r_fill;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_average      = r_average;
    assign o_samples_held = r_held;
    assign o_window_size  = r_wsize;

`ifndef SYNTH
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> (r_fill == '0) && (r_sum == '0) && (r_ptr == '0))
        else $error("window not cleared by a window size write");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !w_full && !i_cfg_wr) |=> r_fill == $past(r_fill) + HELD_BITS'(1))
        else $error("fill count did not advance while filling");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> r_fill <= w_eff)
        else $error("fill count beyond window");
`endif

endmodule

// File: rtl/sliding_window_average_top.sv
// Top level of the sliding window average: channels, register port, controller and datapath.
//
//  channel   direction  handshake        payload
//  i_in      in         valid / ready    sample (18-bit signed)
//  o_out     out        valid / ready    average (34-bit signed, 16 fraction bits), samples_held
//  apb       in         psel / penable   window_size at byte address 0 (pready always high)
//
// An item goes from acceptance to its result in the output register in steps: it updates
// the ring store, running sum and fill count, loads the divider, runs the restoring
// divider one quotient bit per cycle, then hands off the result.
// The next item is taken in the cycle after the hand-off, even if the result still waits,
// so the block takes no new sample before it is through with the last one.
// Reset (synchronous, active low) sets window_size to 1 and empties the window; the sample
// store itself is not cleared, since it is only read back after it has been refilled.
// A stalled output holds the divider result and keeps the input channel closed.
module sliding_window_average_top import swa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swa_in_if.sink                i_in,
    swa_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    t_swa_cmd              w_cmd;
    t_swa_sts              w_sts;
    logic                  w_cfg_wr;
    logic [WSIZE_BITS-1:0] w_wsize;

    // Register index is the word address; only window_size exists
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata   = (paddr[2] == REG_WINDOW_SIZE) ? PDATA_BITS'(w_wsize) : '0;

    swa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    swa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample       (i_in.sample),
        .i_cfg_wr       (w_cfg_wr),
        .i_cfg_data     (pwdata[WSIZE_BITS-1:0]),
        .o_window_size  (w_wsize),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_average      (o_out.average),
        .o_samples_held (o_out.samples_held)
    );

endmodule

// File: sim/sliding_window_average_checker.sv
// Checker for the sliding window average: tracks the window, predicts each mean, compares results.
module sliding_window_average_checker import swa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swa_in_if                     i_in,
    swa_out_if                    i_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    input  logic [PDATA_BITS-1:0] prdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_results_checked,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic [HELD_BITS-1:0]       samples_held;
    } mean_t;

    logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic [PTR_BITS-1:0]           oldest;
    logic [HELD_BITS-1:0]          held;
    logic signed [SUM_BITS-1:0]    window_sum;
    logic [WSIZE_BITS-1:0]         window_size;
    mean_t                         expected_means [$];
    int                            errors;
    int                            checked;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t checker: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic void empty_window();
        oldest     = '0;
        held       = '0;
        window_sum = '0;
    endfunction

    // Zero acts as one; anything past the store depth saturates.
    function automatic int active_window();
        if (window_size == 0)
            return 1;
        if (window_size > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(window_size);
    endfunction

    function automatic mean_t take_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int    w;
        mean_t m;
        w = active_window();
        if (int'(held) < w) begin
            ring[held[PTR_BITS-1:0]] = x;
            held = held + 1'b1;
        end else begin
            // drop the oldest sample and put the new one in its slot
            window_sum   = window_sum - ring[oldest];
            ring[oldest] = x;
            oldest       = (int'(oldest) + 1 >= w) ? '0 : oldest + 1'b1;
        end
        window_sum     = window_sum + x;
        m.average      = AVG_BITS'((longint'(window_sum) <<< FRACTION_BITS) / longint'(held));
        m.samples_held = held;
        return m;
    endfunction

    always @(posedge i_clk) begin : monitor
        mean_t want;
        if (!i_rst_n) begin
            window_size = WINDOW_RESET;
            empty_window();
            expected_means.delete();
        end else begin
            if (psel && penable && pready && (paddr >> 2) == REG_WINDOW_SIZE) begin
                if (pwrite) begin
                    window_size = pwdata[WSIZE_BITS-1:0];
                    empty_window();
                end else if (prdata !== PDATA_BITS'(window_size)) begin
                    report_mismatch("window_size readback", prdata, window_size);
                end
            end
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (expected_means.size() == 0) begin
                    report_mismatch("result with no sample pending, average",
                                    i_out.average, 0);
                end else begin
                    want = expected_means.pop_front();
                    if (i_out.average !== want.average)
                        report_mismatch("average", i_out.average, want.average);
                    if (i_out.samples_held !== want.samples_held)
                        report_mismatch("samples_held", i_out.samples_held, want.samples_held);
                end
            end
            if (i_in.valid && i_in.ready)
                expected_means.push_back(take_sample(i_in.sample));
        end
        o_fail_count      <= errors;
        o_results_checked <= checked;
        o_pending         <= expected_means.size();
    end

endmodule

// File: sim/tb_sliding_window_average_top.sv
// Testbench top for the sliding window average: stimulus, register writes, idling and verdict.
module tb_sliding_window_average_top import swa_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 7;
    // No item may go this long without any handshake in a correct run; the longest
    // deliberate quiet stretch is the long output stall below.
    localparam int QUIET_LIMIT  = 4000;
    // Wait at the end past the time one item takes to its result, for strays.
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_STALL   = 400;
    localparam int STALL_AFTER  = 300;
    localparam int PHASES       = 8;
    localparam int RANDOM_ITEMS = 1860;
    localparam int REG_SPARE    = 1;  // index with no register behind it

    localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_SIZE = PADDR_BITS'(REG_WINDOW_SIZE) << 2;
    localparam logic [PADDR_BITS-1:0] ADDR_SPARE       = PADDR_BITS'(REG_SPARE << 2);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;
    int fail_count;
    int results_checked;
    int pending;

    // Window settings of the random part: small, zero, oversized (saturates to the full
    // store), exactly full, one. The oversized phase runs past one whole ring wrap.
    int phase_window [PHASES] = '{2, 7, 0, 33, 2047, 1024, 1, 100};
    int phase_items  [PHASES] = '{80, 120, 40, 150, 1100, 60, 60, 250};

    swa_in_if  in_ch ();
    swa_out_if out_ch ();

    always #10 i_clk = ~i_clk;

    sliding_window_average_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sliding_window_average_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (in_ch),
        .i_out             (out_ch),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_fail_count      (fail_count),
        .o_results_checked (results_checked),
        .o_pending         (pending)
    );

    // Offer one sample: idle at random first, then hold it until the block takes it.
    // Returns at the edge where the item was accepted, with valid still high.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid  <= 1'b0;
            in_ch.sample <= SAMPLE_BITS'($urandom);
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and wait until every sample sent so far has had its mean checked,
    // so the block is idle and a register write is safe.
    task automatic end_phase();
        in_ch.valid <= 1'b0;
        while (results_checked < items_sent) @(posedge i_clk);
    endtask

    // One register access: setup cycle, access cycle, then back to the idle bus.
    task automatic apb_transfer(input logic write, input logic [PADDR_BITS-1:0] addr,
                                input logic [PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write window_size with random junk above the register's bits, then read it back.
    task automatic configure_window(input logic [WSIZE_BITS-1:0] size);
        logic [PDATA_BITS-1:0] data;
        data                 = $urandom;
        data[WSIZE_BITS-1:0] = size;
        apb_transfer(1'b1, ADDR_WINDOW_SIZE, data);
        apb_transfer(1'b0, ADDR_WINDOW_SIZE, '0);
        settings_used++;
    endtask

    // Mostly full-range random samples with the extremes mixed in; lean_high pushes the
    // running sum toward its top end in the largest window.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input bit lean_high);
        int roll;
        roll = $urandom_range(99);
        if (lean_high)
            return (roll < 85) ? SAMPLE_MAX : SAMPLE_BITS'($urandom);
        if (roll < 5)
            return SAMPLE_MAX;
        if (roll < 10)
            return SAMPLE_MIN;
        return SAMPLE_BITS'($urandom);
    endfunction

    // Result side: random back-pressure, plus one long hold-off once enough results
    // have passed, so the block fills up and closes its input while samples wait.
    initial begin : receiver
        int hold_left;
        int taken;
        bit stall_done;
        hold_left    = 0;
        taken        = 0;
        stall_done   = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                taken++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (taken == STALL_AFTER && !stall_done) begin
                stall_done   = 1'b1;
                hold_left    = LONG_STALL;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run if nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sliding_window_average_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int r;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window of one after reset: read back the reset value, then each mean is
        // the sample itself. Hit both extremes and the values around zero.
        apb_transfer(1'b0, ADDR_WINDOW_SIZE, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(SAMPLE_BITS'(-1));
        send_sample(SAMPLE_BITS'(1));
        end_phase();

        // Zero must behave as a window of one.
        configure_window('0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        end_phase();

        // Window of three: fill with the maximum, wrap once, then swing to the minimum
        // so the sum runs through both ends of its range for this window.
        configure_window(WSIZE_BITS'(3));
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (3) send_sample(SAMPLE_MIN);
        end_phase();

        // A write to an index with no register must leave the window untouched.
        apb_transfer(1'b1, ADDR_SPARE, $urandom);
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(1));
        end_phase();

        // Random part. Idling: sender light and receiver heavy for the first third,
        // reversed for the second, none for the rest.
        r = 0;
        for (int p = 0; p < PHASES; p++) begin
            configure_window(WSIZE_BITS'(phase_window[p]));
            for (int k = 0; k < phase_items[p]; k++) begin
                if (r < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 24;
                    recv_idle_pct = 48;
                end else if (r < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 48;
                    recv_idle_pct = 24;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_sample(pick_sample(phase_window[p] > MAX_WINDOW && k < MAX_WINDOW));
                r++;
            end
            end_phase();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d samples over %0d window settings (zero, one, full, oversized),",
                 items_sent, settings_used);
        $display("with idling on both sides, a %0d-cycle output hold-off and a spare-index write.",
                 LONG_STALL);
        if (fail_count == 0 && pending == 0) begin
            $display("sliding_window_average_top: match");
        end else begin
            $display("sliding_window_average_top: mismatch");
        end
        $finish;
    end

endmodule
